>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the page bitmap allocator.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> hw/rtl/pba_pkg.sv
// Types, constants and helper functions of the page bitmap allocator.
// Depends on nothing; used by page_bitmap_allocator_core.
package pba_pkg;

   // Fixed widths of the beat fields and of a bitmap word.
   localparam int PAGE_IDX_W  = 10;
   localparam int WORD_BITS   = 32;
   localparam int BIT_SEL_W   = 5;
   // Number of words that a page index can ever reach.
   localparam int INDEX_WORDS = (1 << PAGE_IDX_W) / WORD_BITS;
   localparam logic [WORD_BITS-1:0] ALL_TAKEN = 32'hFFFF_FFFF;

   // Request codes.
   typedef enum logic [1:0] {
      MODE_TAKE  = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN,
      ST_ENCODE
   } state_type;

   typedef struct packed {
      mode_type                mode;
      logic [PAGE_IDX_W-1:0]   page_index;
   } req_payload_type;

   typedef struct packed {
      logic                    free_found;
      logic [PAGE_IDX_W-1:0]   first_free;
      logic                    index_error;
   } rsp_payload_type;

   // Position of the lowest clear bit of a word that is not all ones,
   // found by halving the search window five times.
   function automatic logic [BIT_SEL_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
      logic [WORD_BITS-1:0] v;
      logic [BIT_SEL_W-1:0] pos;
      v   = ~word;
      pos = '0;
      for (int i = BIT_SEL_W - 1; i >= 0; i--) begin
         if ((v & ((32'd1 << (1 << i)) - 32'd1)) == 32'd0) begin
            v      = v >> (1 << i);
            pos[i] = 1'b1;
         end
      end
      return pos;
   endfunction

endpackage

>>> hw/rtl/page_bitmap_allocator_core.sv
// Page bitmap allocator: one usage bit per page frame in a word memory.
// Flow: the word that holds the page is read and written back, then words are scanned from
// word 0 until one has a free page or all MEM_WORDS are read, and the result is formed.
// Throughput: one request at a time; the scan reads one memory word per cycle.
// Reset: synchronous; per-word valid bits make the whole map read as free at once.
// Depends on pba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module page_bitmap_allocator_core #(
   parameter int PAGE_COUNT = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pba_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output pba_pkg::rsp_payload_type rsp_payload
);

   localparam int WORD_COUNT = (PAGE_COUNT + pba_pkg::WORD_BITS - 1) / pba_pkg::WORD_BITS;
   // Words above the reach of a page index are never written and stay free.
   localparam int MEM_WORDS  = (WORD_COUNT < pba_pkg::INDEX_WORDS) ?
                               WORD_COUNT : pba_pkg::INDEX_WORDS;
   localparam int ADDR_W     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int CNT_W      = $clog2(MEM_WORDS + 1);
   localparam int TAIL_BITS  = PAGE_COUNT % pba_pkg::WORD_BITS;
   localparam logic [pba_pkg::WORD_BITS-1:0] TAIL_MASK = (TAIL_BITS == 0) ? '0 :
      ~((32'd1 << TAIL_BITS) - 32'd1);
   localparam logic BEYOND_FREE = (WORD_COUNT > MEM_WORDS);
   localparam logic [pba_pkg::PAGE_IDX_W-1:0] BEYOND_PAGE =
      pba_pkg::PAGE_IDX_W'(MEM_WORDS * pba_pkg::WORD_BITS);

   // Usage memory and its per-word valid bits.
   logic [pba_pkg::WORD_BITS-1:0] mem [MEM_WORDS];
   logic [MEM_WORDS-1:0]          word_valid_ff, word_valid_in;
   logic [pba_pkg::WORD_BITS-1:0] rd_data_ff;
   logic                          rd_valid_ff;
   logic                          rd_en, wr_en;
   logic [ADDR_W-1:0]             rd_addr, wr_addr;
   logic [pba_pkg::WORD_BITS-1:0] wr_data;

   // Control and request registers.
   pba_pkg::state_type            state_ff, state_in;
   pba_pkg::mode_type             mode_ff, mode_in;
   logic [pba_pkg::PAGE_IDX_W-1:0] index_ff, index_in;
   logic                          error_ff, error_in;
   logic [CNT_W-1:0]              scan_cnt_ff, scan_cnt_in;
   logic                          rd_pend_ff, rd_pend_in;
   logic [ADDR_W-1:0]             chk_ff, chk_in;
   logic                          enc_hit_ff, enc_hit_in;
   logic [pba_pkg::WORD_BITS-1:0] enc_word_ff, enc_word_in;
   logic [ADDR_W-1:0]             enc_num_ff, enc_num_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pba_pkg::rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   logic                          accept;
   logic                          req_error;
   logic [pba_pkg::WORD_BITS-1:0] old_word, scan_view;
   logic                          out_free;

   assign req_stall   = (state_ff != pba_pkg::ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // An index at or above the page count is refused for take and free.
   assign req_error = ((req_payload.mode == pba_pkg::MODE_TAKE) ||
                       (req_payload.mode == pba_pkg::MODE_FREE)) &&
                      (32'(req_payload.page_index) >= PAGE_COUNT);

   // Word as read, with pages past the end shown as taken.
   assign old_word  = rd_valid_ff ? rd_data_ff : '0;
   assign scan_view = (32'(chk_ff) == WORD_COUNT - 1) ? (old_word | TAIL_MASK) : old_word;

   // Next state, memory accesses and result.
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      index_in       = index_ff;
      error_in       = error_ff;
      scan_cnt_in    = scan_cnt_ff;
      rd_pend_in     = 1'b0;
      chk_in         = chk_ff;
      enc_hit_in     = enc_hit_ff;
      enc_word_in    = enc_word_ff;
      enc_num_in     = enc_num_ff;
      word_valid_in  = word_valid_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      rd_en          = 1'b0;
      rd_addr        = scan_cnt_ff[ADDR_W-1:0];
      wr_en          = 1'b0;
      wr_addr        = ADDR_W'(index_ff >> pba_pkg::BIT_SEL_W);
      wr_data        = old_word;
      if (mode_ff == pba_pkg::MODE_TAKE) begin
         wr_data = old_word | (32'd1 << index_ff[pba_pkg::BIT_SEL_W-1:0]);
      end else begin
         wr_data = old_word & ~(32'd1 << index_ff[pba_pkg::BIT_SEL_W-1:0]);
      end

      case (state_ff)
         pba_pkg::ST_IDLE: begin
            // Take the beat and fetch the word that holds its page.
            if (accept) begin
               mode_in  = req_payload.mode;
               index_in = req_payload.page_index;
               error_in = req_error;
               rd_en    = 1'b1;
               rd_addr  = ADDR_W'(req_payload.page_index >> pba_pkg::BIT_SEL_W);
               state_in = pba_pkg::ST_MODIFY;
            end
         end
         pba_pkg::ST_MODIFY: begin
            // Write back the changed word on a take or free without error, or drop every valid bit on clear.
            if (mode_ff == pba_pkg::MODE_CLEAR) begin
               word_valid_in = '0;
            end else if (!error_ff && ((mode_ff == pba_pkg::MODE_TAKE) ||
                                       (mode_ff == pba_pkg::MODE_FREE))) begin
               wr_en                  = 1'b1;
               word_valid_in[wr_addr] = 1'b1;
            end
            scan_cnt_in = '0;
            state_in    = pba_pkg::ST_SCAN;
         end
         pba_pkg::ST_SCAN: begin
            // One read is issued per cycle while the previous word is checked.
            if (rd_pend_ff && (scan_view != pba_pkg::ALL_TAKEN)) begin
               enc_hit_in  = 1'b1;
               enc_word_in = scan_view;
               enc_num_in  = chk_ff;
               state_in    = pba_pkg::ST_ENCODE;
            end else if (scan_cnt_ff == CNT_W'(MEM_WORDS)) begin
               enc_hit_in = 1'b0;
               state_in   = pba_pkg::ST_ENCODE;
            end else begin
               rd_en       = 1'b1;
               rd_pend_in  = 1'b1;
               chk_in      = scan_cnt_ff[ADDR_W-1:0];
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end
         end
         pba_pkg::ST_ENCODE: begin
            // Form the result once the output register can take it.
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.index_error = error_ff;
               if (enc_hit_ff) begin
                  rsp_payload_in.free_found = 1'b1;
                  rsp_payload_in.first_free = pba_pkg::PAGE_IDX_W'(
                     {enc_num_ff, pba_pkg::lowest_zero(enc_word_ff)});
               end else if (BEYOND_FREE) begin
                  rsp_payload_in.free_found = 1'b1;
                  rsp_payload_in.first_free = BEYOND_PAGE;
               end else begin
                  rsp_payload_in.free_found = 1'b0;
                  rsp_payload_in.first_free = '0;
               end
               state_in = pba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pba_pkg::ST_IDLE;
         end
      endcase
   end

   // Usage memory: one read port with registered data, one write port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= word_valid_ff[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pba_pkg::ST_IDLE;
         word_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_pend_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_pend_ff    <= rd_pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      index_ff       <= index_in;
      error_ff       <= error_in;
      scan_cnt_ff    <= scan_cnt_in;
      chk_ff         <= chk_in;
      enc_hit_ff     <= enc_hit_in;
      enc_word_ff    <= enc_word_in;
      enc_num_ff     <= enc_num_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Checks on the controller.
   `ASSERT_NEVER(a_rd_wr_overlap, clock, reset, rd_en && wr_en)
   `ASSERT_NEVER(a_write_on_error, clock, reset, wr_en && error_ff)
   `ASSERT_NEVER(a_scan_bound, clock, reset, scan_cnt_ff > CNT_W'(MEM_WORDS) && state_ff == pba_pkg::ST_SCAN)
   `ASSERT_PROP(a_none_is_zero, clock, reset, (rsp_valid && !rsp_payload.free_found) |-> (rsp_payload.first_free == '0))
   `ASSERT_PROP(a_accept_stalls, clock, reset, accept |=> req_stall)

endmodule
